FILE: rtl/bounded_array_list_defines.svh
// ----------------------------------------------------------------------------
// Bounded array list: assertion macros
// Shared concurrent assertion forms used by the RTL of the list block.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define BAL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define BAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list package
// Widths, request and status codes, and the structs shared by the list RTL.
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int KIND_W  = 3;
	localparam int POS_W   = 4;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 5;
	// Largest count the 5-bit limit register can allow.
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam int DEPTH_DEF = 16;

	localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(16);
	localparam logic [WORD_W-1:0] MIN_WORD  = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT_AT   = 3'd0,
		KIND_APPEND      = 3'd1,
		KIND_REMOVE_AT   = 3'd2,
		KIND_REMOVE_LAST = 3'd3,
		KIND_READ_AT     = 3'd4,
		KIND_CLEAR       = 3'd5
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADIDX = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [CNT_W-1:0]  idx;
		logic [WORD_W-1:0] value;
	} cell_cmd_t;

	// One result item.
	typedef struct packed {
		status_t            status;
		logic signed [WORD_W-1:0] read_value;
		logic [CNT_W-1:0]   count;
		logic               full;
		logic               empty;
	} result_t;

endpackage

FILE: rtl/bal_cell.sv
// ----------------------------------------------------------------------------
// Bounded array list cell
// One entry of the list; takes a neighbor's word on insert or remove shifts.
// ----------------------------------------------------------------------------
module bal_cell
	import bal_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [WORD_W-1:0] left_data,
	input  logic [WORD_W-1:0] right_data,
	output logic [WORD_W-1:0] data_q
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [WORD_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		if (cmd.ins) begin
			if (MY_IDX == cmd.idx) begin
				data_d = cmd.value;
			end else if (MY_IDX > cmd.idx) begin
				data_d = left_data;
			end
		end else if (cmd.rem && (MY_IDX >= cmd.idx)) begin
			data_d = right_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

FILE: rtl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded array list control
// Holds count and limit, decodes requests, drives the cell row, forms results.
// ----------------------------------------------------------------------------
module bal_ctrl
	import bal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              accept,
	input  logic [KIND_W-1:0] kind,
	input  logic [POS_W-1:0]  position,
	input  logic [WORD_W-1:0] value,
	input  logic [WORD_W-1:0] rd_data,
	output cell_cmd_t         cmd,
	output result_t           res
);

	localparam int NCELL = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
	localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(NCELL);

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] occ_d;
	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] pos_ext;
	logic             full_now;

	always_comb begin
		lim = (cap_q == '0) ? CNT_W'(1) : cap_q;
		if (lim > LIM_MAX) begin
			lim = LIM_MAX;
		end
	end

	assign pos_ext  = CNT_W'(position);
	assign full_now = (occ_q >= lim);

	always_comb begin
		cmd            = '0;
		cmd.idx        = pos_ext;
		cmd.value      = value;
		occ_d          = occ_q;
		res.status     = ST_OK;
		res.read_value = '0;
		case (kind_t'(kind))
			KIND_INSERT_AT: begin
				if (pos_ext > occ_q) begin
					res.status = ST_BADIDX;
				end else if (full_now) begin
					res.status = ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					occ_d   = occ_q + CNT_W'(1);
				end
			end
			KIND_APPEND: begin
				if (full_now) begin
					res.status = ST_FULL;
				end else begin
					cmd.ins = 1'b1;
					cmd.idx = occ_q;
					occ_d   = occ_q + CNT_W'(1);
				end
			end
			KIND_REMOVE_AT: begin
				if (occ_q == '0) begin
					res.status = ST_EMPTY;
				end else if (pos_ext >= occ_q) begin
					res.status = ST_BADIDX;
				end else begin
					cmd.rem = 1'b1;
					occ_d   = occ_q - CNT_W'(1);
				end
			end
			KIND_REMOVE_LAST: begin
				if (occ_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					occ_d = occ_q - CNT_W'(1);
				end
			end
			KIND_READ_AT: begin
				if (pos_ext < occ_q) begin
					res.read_value = rd_data;
				end else begin
					res.status     = ST_BADIDX;
					res.read_value = MIN_WORD;
				end
			end
			KIND_CLEAR: begin
				occ_d = '0;
			end
			default: begin
				res.status = ST_BADIDX;
			end
		endcase
		// Move cells only on a real transfer.
		if (!accept) begin
			cmd.ins = 1'b0;
			cmd.rem = 1'b0;
		end
		res.count = occ_d;
		res.full  = (occ_d >= lim);
		res.empty = (occ_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			occ_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				occ_q <= occ_d;
			end
		end
	end

endmodule

FILE: rtl/bounded_array_list.sv
// Result: a request's result is registered and presented in the cycle after its input transfer.
// Throughput: one request per cycle while results are taken; cells from the
// position on shift together; a single output register parts input and output.
// Reset: count 0, capacity limit 16, no result pending; entry contents are
// undefined until written and carry no reset.
// ----------------------------------------------------------------------------
// Bounded array list
// Ordered list of signed 32-bit words with insert, append, remove, read and
// clear, built as a row of shifting cells behind a small control unit.
// ----------------------------------------------------------------------------
`include "bounded_array_list_defines.svh"

module bounded_array_list
	import bal_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration write channel: capacity limit
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CNT_W-1:0]         cfg_data,
	// Request channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        kind,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] value,
	// Result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STAT_W-1:0]        status,
	output logic signed [WORD_W-1:0] read_value,
	output logic [CNT_W-1:0]         entry_count,
	output logic                     is_full,
	output logic                     is_empty
);

	// Only the first min(DEPTH, 31) entries are reachable: the limit is 5 bits.
	localparam int NCELL = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
	localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(NCELL);

	logic              accept;
	cell_cmd_t         cmd;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] cell_data [NCELL];

	// Terms used by the checks at the end of the module.
	logic              clear_xfer;
	logic              res_cleared;
	logic              full_res;
	logic              full_flags;
	logic              cnt_ok;

	// Configuration writes are always taken, unchecked; the user must send them only while the block is idle.
	assign cfg_ready = 1'b1;

	// Take a new request whenever the output register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	bal_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.accept   (accept),
		.kind     (kind),
		.position (position),
		.value    (value),
		.rd_data  (rd_data),
		.cmd      (cmd),
		.res      (res)
	);

	// Row of cells: cell i takes cell i-1 on insert, cell i+1 on remove.
	// The first cell's left input is never selected; the last cell's right
	// input is its own word, so it holds on a remove.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		bal_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.left_data  ((i == 0) ? cmd.value : cell_data[(i == 0) ? 0 : i-1]),
			.right_data (cell_data[(i == NCELL-1) ? i : i+1]),
			.data_q     (cell_data[i])
		);
	end

	// Read select: one-hot match of the position against each cell index.
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (CNT_W'(position) == CNT_W'(i)) begin
				rd_data = rd_data | cell_data[i];
			end
		end
	end

	// Output register: load on a request transfer, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign read_value  = res_q.read_value;
	assign entry_count = res_q.count;
	assign is_full     = res_q.full;
	assign is_empty    = res_q.empty;

	assign clear_xfer  = accept && (kind_t'(kind) == KIND_CLEAR);
	assign res_cleared = out_valid && (entry_count == '0) && is_empty;
	assign full_res    = out_valid && (status == ST_FULL);
	assign full_flags  = is_full && !is_empty;
	assign cnt_ok      = (entry_count <= LIM_MAX) && (is_empty == (entry_count == '0));

	`BAL_ASSERT_NEXT(a_clear_empties, clk, arst_n, clear_xfer, res_cleared, "clear kept entries")
	`BAL_ASSERT_IMPL(a_full_status_flag, clk, arst_n, full_res, full_flags, "full flag low")
	`BAL_ASSERT_IMPL(a_count_bound, clk, arst_n, out_valid, cnt_ok, "entry count out of range")

endmodule

FILE: tb/sv/bounded_array_list_tb.sv
// ----------------------------------------------------------------------------
// Bounded array list testbench
// Sends insert, append, remove, read and clear requests and capacity limit
// writes to the list. Random idle gaps sit on both channels, and there is
// one long result stall. Each result is checked field by field against a
// list kept inside the bench.
// ----------------------------------------------------------------------------
module bounded_array_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bal_pkg::*;

	localparam int LIST_DEPTH   = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 60;
	localparam int SETTLE       = 4;
	localparam int RUN_LIMIT_NS = 4_000_000;

	// Request codes the package leaves unnamed; the block must reject them.
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	localparam logic [WORD_W-1:0] MAX_WORD = 32'h7fff_ffff;

	typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN, ACT_HOLD} step_act_t;
	typedef enum int {STYLE_FILL, STYLE_MIXED, STYLE_DRAIN} mix_t;

	// One entry of the stimulus plan: a request, a limit write, a wait for
	// all results, or a trigger for the long result stall.
	typedef struct packed {
		step_act_t         act;
		logic [KIND_W-1:0] op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  limit;
		logic [5:0]        gap;
	} step_t;

	typedef struct packed {
		logic [LIST_DEPTH-1:0][WORD_W-1:0] words;
		logic [CNT_W-1:0]                  count;
		logic [CNT_W-1:0]                  limit;
	} list_state_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CNT_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [KIND_W-1:0]        kind = '0;
	logic [POS_W-1:0]         position = '0;
	logic signed [WORD_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STAT_W-1:0]        status;
	logic signed [WORD_W-1:0] read_value;
	logic [CNT_W-1:0]         entry_count;
	logic                     is_full;
	logic                     is_empty;

	// Handshake between the request driver and the result acceptor: a
	// toggle asks for one long stall.
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;

	step_t       pending_steps[$];
	result_t     due_results[$];
	list_state_t plan_list;
	list_state_t list_model;
	logic        gen_burst;
	int          gen_requests;
	int          mix_count;
	int          mismatches;
	int          results_checked;
	int          limit_writes;
	int          status_seen[4];

	bounded_array_list #(
		.DEPTH(LIST_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.position    (position),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count),
		.is_full     (is_full),
		.is_empty    (is_empty)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Apply one request to a list and return the result it must produce.
	// A limit of zero behaves as one and anything above the depth as the
	// depth; a lowered limit keeps the entries but blocks further adds.
	function automatic result_t apply_request(inout list_state_t ls,
			input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] word);
		result_t     res;
		int unsigned lim;
		logic        at_limit;
		int          i;
		lim = (ls.limit == 0) ? 1 : ((ls.limit > LIST_DEPTH) ? LIST_DEPTH : ls.limit);
		at_limit = (ls.count >= lim);
		res.status = ST_OK;
		res.read_value = '0;
		case (op)
		KIND_INSERT_AT: begin
			if (pos > ls.count)
				res.status = ST_BADIDX;
			else if (at_limit || ls.count >= LIST_DEPTH)
				res.status = ST_FULL;
			else begin
				// Shift the tail up, top entry first.
				for (i = LIST_DEPTH - 1; i > 0; i--)
					if (i > pos && i <= ls.count)
						ls.words[i] = ls.words[i - 1];
				ls.words[pos] = word;
				ls.count++;
			end
		end
		KIND_APPEND: begin
			if (at_limit || ls.count >= LIST_DEPTH)
				res.status = ST_FULL;
			else begin
				ls.words[ls.count] = word;
				ls.count++;
			end
		end
		KIND_REMOVE_AT: begin
			if (ls.count == 0)
				res.status = ST_EMPTY;
			else if (pos >= ls.count)
				res.status = ST_BADIDX;
			else begin
				// Close the gap, lowest entry first.
				for (i = 0; i < LIST_DEPTH - 1; i++)
					if (i >= pos && i + 1 < ls.count)
						ls.words[i] = ls.words[i + 1];
				ls.count--;
			end
		end
		KIND_REMOVE_LAST: begin
			if (ls.count == 0)
				res.status = ST_EMPTY;
			else
				ls.count--;
		end
		KIND_READ_AT: begin
			if (pos < ls.count)
				res.read_value = ls.words[pos];
			else begin
				res.status = ST_BADIDX;
				res.read_value = MIN_WORD;
			end
		end
		KIND_CLEAR: ls.count = '0;
		default: res.status = ST_BADIDX;
		endcase
		res.count = ls.count;
		res.full = (ls.count >= lim);
		res.empty = (ls.count == 0);
		return res;
	endfunction

	// Queue a request and advance the planning copy of the list, so that
	// later positions can be aimed at the live part of the list.
	task automatic push_req(input logic [KIND_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] word);
		step_t       s;
		int unsigned r;
		r = $urandom_range(0, 99);
		s = '0;
		s.act = ACT_REQ;
		s.op = op;
		s.pos = pos;
		s.word = word;
		// Mostly back to back, some short gaps, a few long ones.
		if (gen_burst || r < 60)
			s.gap = '0;
		else if (r < 90)
			s.gap = 6'($urandom_range(1, 3));
		else
			s.gap = 6'($urandom_range(8, 25));
		void'(apply_request(plan_list, op, pos, word));
		pending_steps.push_back(s);
		gen_requests++;
	endtask

	// The driver holds a limit write until the block has no work left.
	task automatic push_cfg(input logic [CNT_W-1:0] limit);
		step_t s;
		s = '0;
		s.act = ACT_CFG;
		s.limit = limit;
		plan_list.limit = limit;
		pending_steps.push_back(s);
	endtask

	task automatic push_drain();
		step_t s;
		s = '0;
		s.act = ACT_DRAIN;
		pending_steps.push_back(s);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Request driver: offer the next planned step once the current transfer
	// is done and its idle gap has run out. Keep valid and payload steady
	// while the block stalls.
	always @(posedge clk) begin : request_driver
		step_t head;
		logic  next_valid;
		logic  next_cfg;
		int    gap_left;
		int    in_flight;
		if (arst_n) begin
			// Track requests sent but not yet answered, from sampled handshakes.
			in_flight = in_flight + int'(in_valid && in_ready) - int'(out_valid && out_ready);
			if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready))) begin
				next_valid = 1'b0;
				next_cfg = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (pending_steps.size() != 0) begin
					head = pending_steps[0];
					case (head.act)
					ACT_REQ: begin
						next_valid = 1'b1;
						kind <= head.op;
						position <= head.pos;
						value <= head.word;
						gap_left = head.gap;
						void'(pending_steps.pop_front());
					end
					ACT_CFG: begin
						// Write the limit only with the block fully idle.
						if (in_flight == 0) begin
							next_cfg = 1'b1;
							cfg_data <= head.limit;
							void'(pending_steps.pop_front());
						end
					end
					ACT_DRAIN: begin
						if (in_flight == 0)
							void'(pending_steps.pop_front());
					end
					default: begin
						// Ask for the long stall and keep sending meanwhile.
						hold_req <= ~hold_req;
						void'(pending_steps.pop_front());
					end
					endcase
				end
				in_valid <= next_valid;
				cfg_valid <= next_cfg;
			end
		end
	end

	// Result acceptor: random stalls, a recurring fully ready window, and the
	// long stall when the driver asks for it.
	always @(posedge clk) begin : result_acceptor
		int          stall_left;
		int          cycle_no;
		int unsigned r;
		if (arst_n) begin
			cycle_no++;
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (cycle_no % 256 < 64)
				out_ready <= 1'b1;
			else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					out_ready <= 1'b1;
				else begin
					stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(6, 20);
					out_ready <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each result transfer against the oldest result
	// due, then record new limits and predict new requests from this edge.
	always @(posedge clk) begin : result_monitor
		result_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (!$isunknown(status))
					status_seen[status]++;
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing due, status %0h count %0h",
						$time, status, entry_count);
					mismatches++;
				end else begin
					due = due_results.pop_front();
					check_field("status", 32'(due.status), 32'(status));
					check_field("read_value", due.read_value, read_value);
					check_field("entry_count", 32'(due.count), 32'(entry_count));
					check_field("is_full", 32'(due.full), 32'(is_full));
					check_field("is_empty", 32'(due.empty), 32'(is_empty));
				end
			end
			if (cfg_valid && cfg_ready) begin
				list_model.limit = cfg_data;
				limit_writes++;
			end
			if (in_valid && in_ready)
				due_results.push_back(apply_request(list_model, kind, position, value));
		end
	end

	initial begin
		mix_t             style;
		int               add_share;
		int               len;
		int               cnt;
		int unsigned      r;
		logic [KIND_W-1:0] op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  limit;

		plan_list = '0;
		plan_list.limit = CAP_RESET;
		list_model = plan_list;
		gen_burst = 1'b0;

		// Directed: empty list first, so every removal and read must fail.
		push_req(KIND_REMOVE_LAST, 0, '0);
		push_req(KIND_REMOVE_AT, 0, '0);
		push_req(KIND_READ_AT, 0, '0);
		push_req(KIND_INSERT_AT, 1, '0);
		// Extreme words at the front, the end and in the middle.
		push_req(KIND_INSERT_AT, 0, MAX_WORD);
		push_req(KIND_APPEND, 0, MIN_WORD);
		push_req(KIND_INSERT_AT, 1, '0);
		push_req(KIND_INSERT_AT, 3, '1);
		push_req(KIND_READ_AT, 0, '0);
		push_req(KIND_READ_AT, 3, '0);
		push_req(KIND_READ_AT, 4, '0);
		push_req(KIND_REMOVE_AT, 4, '0);
		push_req(KIND_REMOVE_AT, 1, '0);
		push_req(KIND_SPARE_A, 2, 32'h5a5a_5a5a);
		push_req(KIND_SPARE_B, 15, 32'ha5a5_a5a5);
		push_req(KIND_READ_AT, 15, '0);
		push_req(KIND_REMOVE_LAST, 0, '0);
		push_req(KIND_CLEAR, 0, '0);
		// A zero limit acts as one: second add answers full, and an
		// insert past the end still answers bad index.
		push_cfg(0);
		push_req(KIND_APPEND, 0, 32'h1234_5678);
		push_req(KIND_APPEND, 0, 32'h1);
		push_req(KIND_INSERT_AT, 0, 32'h2);
		push_req(KIND_INSERT_AT, 5, 32'h3);
		push_req(KIND_READ_AT, 0, '0);
		push_drain();

		// Random mixes. Fill to the depth first, then lower the limit below
		// the count, then walk through the extremes and random limits.
		mix_count = 0;
		while (gen_requests < RANDOM_ITEMS) begin
			case (mix_count)
			0: begin limit = 5'd16; style = STYLE_FILL; end
			1: begin limit = 5'd4; style = STYLE_MIXED; end
			2: begin limit = 5'd31; style = STYLE_FILL; end
			3: begin limit = 5'd1; style = STYLE_MIXED; end
			4: begin limit = 5'd0; style = STYLE_DRAIN; end
			5: begin limit = 5'd16; style = STYLE_DRAIN; end
			default: begin
				limit = CNT_W'($urandom_range(0, 31));
				style = mix_t'($urandom_range(0, 2));
			end
			endcase
			push_cfg(limit);
			gen_burst = (mix_count % 3 == 2);
			if (mix_count == 2)
				pending_steps.push_back('{act: ACT_HOLD, default: '0});
			add_share = (style == STYLE_FILL) ? 70 : ((style == STYLE_MIXED) ? 45 : 20);
			len = $urandom_range(25, 50);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					op = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
				else if (r < 4)
					op = KIND_CLEAR;
				else begin
					r = $urandom_range(0, 99);
					if (r < add_share)
						op = r[0] ? KIND_INSERT_AT : KIND_APPEND;
					else if (r < add_share + 15)
						op = KIND_READ_AT;
					else
						op = r[0] ? KIND_REMOVE_AT : KIND_REMOVE_LAST;
				end
				// Aim positions at the live entries, with some stray ones.
				cnt = int'(plan_list.count);
				if ($urandom_range(0, 6) == 0)
					pos = POS_W'($urandom);
				else if (op == KIND_INSERT_AT)
					pos = (cnt > 15) ? POS_W'(15) : POS_W'($urandom_range(0, cnt));
				else if (cnt == 0)
					pos = '0;
				else
					pos = POS_W'($urandom_range(0, cnt - 1));
				r = $urandom_range(0, 19);
				case (r)
				0: word = MIN_WORD;
				1: word = MAX_WORD;
				2: word = '0;
				3: word = '1;
				default: word = $urandom;
				endcase
				push_req(op, pos, word);
			end
			if ($urandom_range(0, 3) == 0)
				push_drain();
			mix_count++;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the plan to run out and every result to come back.
		while (pending_steps.size() != 0 || in_valid || cfg_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("Covered %0d requests, %0d limit writes, %0d random mixes, %0d results checked.",
			gen_requests, limit_writes, mix_count, results_checked);
		$display("Statuses seen: %0d ok, %0d bad index, %0d full, %0d empty.",
			status_seen[ST_OK], status_seen[ST_BADIDX], status_seen[ST_FULL],
			status_seen[ST_EMPTY]);
		if (mismatches == 0)
			$display("[bounded_array_list] OK");
		else
			$display("[bounded_array_list] ERROR");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("Timeout: %0d results still due, %0d steps unsent.",
			due_results.size(), pending_steps.size());
		$display("[bounded_array_list] ERROR");
		$finish;
	end

endmodule
